// ----- hdl/assert_macros.svh -----
// Assertion macros used by the verification checker of the serial reader.
// No dependencies; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, disabled while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion sampled on the rising clock that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/lcsr_pkg.sv -----
// Shared types, widths and constants of the load cell serial reader.
// No dependencies; imported by every module of the block.
package lcsr_pkg;

    localparam int DATA_BITS   = 24;
    localparam int RAW_W       = 24;
    localparam int DIFF_W      = RAW_W + 1;
    localparam int SCALE_W     = 32;
    localparam int PROD_W      = DIFF_W + SCALE_W + 1;
    localparam int FRAC_SHIFT  = 16;
    localparam int WEIGHT_W    = 41;
    localparam int PHASE_W     = 8;
    localparam int WAIT_W      = 24;
    localparam int BITCNT_W    = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 72;
    localparam int M_USED_W    = 4 + RAW_W + WEIGHT_W;

    localparam logic [RAW_W-1:0]   OFFSET_RST  = RAW_W'(183300);
    localparam logic [SCALE_W-1:0] SCALE_RST   = SCALE_W'(1357639);
    localparam logic [PHASE_W-1:0] PHASE_RST   = PHASE_W'(1);
    localparam logic [WAIT_W-1:0]  TIMEOUT_RST = WAIT_W'(150000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_HIGH,
        ST_LOW,
        ST_GAIN
    } lcsr_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_OFFSET,
        REG_SCALE,
        REG_PHASE_TICKS,
        REG_READY_TIMEOUT
    } cfg_reg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_ticks;
        logic [WAIT_W-1:0]  ready_timeout;
    } timing_cfg_t;

    typedef struct packed {
        logic             sck;
        logic             busy;
        logic             done;
        logic             timed_out;
        logic [RAW_W-1:0] raw;
    } tick_res_t;

endpackage

// ----- hdl/lcsr_ctrl.sv -----
// Tick sequencer of the load cell serial reader: ready wait, clock phases, bit shifting.
// Depends on lcsr_pkg.
module lcsr_ctrl
    import lcsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        start_req,
    input  logic        dt_level,
    input  timing_cfg_t cfg,
    output tick_res_t   res
);

    lcsr_state_t         state_reg, state_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [PHASE_W-1:0]  ptc_reg, ptc_next;
    logic [WAIT_W-1:0]   wait_cnt_reg, wait_cnt_next;
    logic [RAW_W-1:0]    shift_reg, shift_next;
    logic [RAW_W-1:0]    raw_reg, raw_next;

    logic [PHASE_W-1:0]  phase_len;
    logic [PHASE_W:0]    ptc_inc;
    logic                phase_end;
    logic [PHASE_W-1:0]  ptc_adv;
    logic [WAIT_W-1:0]   wait_inc;
    logic [BITCNT_W-1:0] bit_inc;

    assign phase_len = (cfg.phase_ticks == '0) ? PHASE_W'(1) : cfg.phase_ticks;
    assign ptc_inc   = {1'b0, ptc_reg} + (PHASE_W+1)'(1);
    assign phase_end = ptc_inc >= {1'b0, phase_len};
    assign ptc_adv   = phase_end ? '0 : ptc_inc[PHASE_W-1:0];
    assign wait_inc  = wait_cnt_reg + WAIT_W'(1);
    assign bit_inc   = bit_cnt_reg + BITCNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        ptc_next      = ptc_reg;
        wait_cnt_next = wait_cnt_reg;
        shift_next    = shift_reg;
        raw_next      = raw_reg;
        res.sck       = 1'b0;
        res.busy      = 1'b0;
        res.done      = 1'b0;
        res.timed_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start_req) begin
                    state_next    = ST_WAIT;
                    wait_cnt_next = '0;
                end
            end
            ST_WAIT: begin
                res.busy = 1'b1;
                if (!dt_level) begin
                    state_next   = ST_HIGH;
                    bit_cnt_next = '0;
                    ptc_next     = '0;
                    shift_next   = '0;
                end else begin
                    wait_cnt_next = wait_inc;
                    if (wait_inc >= cfg.ready_timeout) begin
                        state_next    = ST_IDLE;
                        bit_cnt_next  = '0;
                        ptc_next      = '0;
                        wait_cnt_next = '0;
                        raw_next      = '0;
                        res.done      = 1'b1;
                        res.timed_out = 1'b1;
                    end
                end
            end
            ST_HIGH: begin
                res.busy = 1'b1;
                res.sck  = 1'b1;
                ptc_next = ptc_adv;
                if (phase_end) begin
                    state_next = ST_LOW;
                end
            end
            ST_LOW: begin
                res.busy = 1'b1;
                ptc_next = ptc_adv;
                if (phase_end) begin
                    shift_next   = {shift_reg[RAW_W-2:0], dt_level};
                    bit_cnt_next = bit_inc;
                    state_next   = (bit_inc >= BITCNT_W'(DATA_BITS)) ? ST_GAIN : ST_HIGH;
                end
            end
            ST_GAIN: begin
                res.busy = 1'b1;
                res.sck  = 1'b1;
                ptc_next = ptc_adv;
                if (phase_end) begin
                    state_next    = ST_IDLE;
                    bit_cnt_next  = '0;
                    ptc_next      = '0;
                    wait_cnt_next = '0;
                    raw_next      = shift_reg;
                    res.done      = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        res.raw = raw_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bit_cnt_reg  <= '0;
            ptc_reg      <= '0;
            wait_cnt_reg <= '0;
            raw_reg      <= '0;
        end else if (step) begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            ptc_reg      <= ptc_next;
            wait_cnt_reg <= wait_cnt_next;
            raw_reg      <= raw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            shift_reg <= shift_next;
        end
    end

endmodule

// ----- hdl/load_cell_adc_serial_reader.sv -----
// Channel   Direction  Content
// s_*       in         one time tick: start request and sampled data line level
// m_*       out        one result per tick: clock level, status, raw reading, weight
// cfg_*     in         register writes: tare offset, scale, phase length, ready timeout
//
// One tick is accepted every cycle while the output is not stalled; each accepted tick's
// result is registered after the sequencer update, then after the 25 x 33 bit weight multiplier.
// The sequencer state advances only on accepted ticks, so stalls on either side
// do not change timing of the serial protocol as counted in ticks.
// Reset is synchronous and active low; it clears the sequencer, the held reading
// and weight, and loads the configuration registers with their defaults.
// Depends on lcsr_pkg and lcsr_ctrl.
module load_cell_adc_serial_reader
    import lcsr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // start_req, dt_level, zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // sck, busy_res, done_res, timed_out,
                                              // raw_value, weight_q16, zero fill
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [RAW_W-1:0]    offset_reg;
    logic [SCALE_W-1:0]  scale_reg;
    timing_cfg_t         timing_reg;

    logic                s_acc;
    logic                out_en;
    tick_res_t           tick_res;

    logic                a_valid_reg;
    tick_res_t           a_res_reg;
    logic signed [DIFF_W-1:0] a_diff_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [PROD_W-1:0] prod;

    logic                m_valid_reg;
    tick_res_t           m_res_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg               <= OFFSET_RST;
            scale_reg                <= SCALE_RST;
            timing_reg.phase_ticks   <= PHASE_RST;
            timing_reg.ready_timeout <= TIMEOUT_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_ZERO_OFFSET:   offset_reg <= cfg_data[RAW_W-1:0];
                REG_SCALE:         scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_PHASE_TICKS:   timing_reg.phase_ticks <= cfg_data[PHASE_W-1:0];
                REG_READY_TIMEOUT: timing_reg.ready_timeout <= cfg_data[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_en   = !m_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || out_en;
    assign s_acc    = s_tvalid && s_tready;

    lcsr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (s_acc),
        .start_req (s_tdata[0]),
        .dt_level  (s_tdata[1]),
        .cfg       (timing_reg),
        .res       (tick_res)
    );

    assign diff_next = $signed({tick_res.raw[RAW_W-1], tick_res.raw})
                     - $signed({offset_reg[RAW_W-1], offset_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_acc) begin
            a_valid_reg <= 1'b1;
        end else if (out_en) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_res_reg  <= tick_res;
            a_diff_reg <= diff_next;
        end
    end

    assign prod = a_diff_reg * $signed({1'b0, scale_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            weight_reg  <= '0;
        end else if (out_en) begin
            m_valid_reg <= a_valid_reg;
            if (a_valid_reg && a_res_reg.done) begin
                weight_reg <= prod[FRAC_SHIFT+WEIGHT_W-1:FRAC_SHIFT];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && a_valid_reg) begin
            m_res_reg <= a_res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_USED_W){1'b0}}, weight_reg, m_res_reg.raw,
                       m_res_reg.timed_out, m_res_reg.done, m_res_reg.busy, m_res_reg.sck};

endmodule

// ----- hdl/lcsr_checker.sv -----
// Port-level checker for the load cell serial reader, attached by bind.
// Depends on assert_macros.svh and lcsr_pkg.
`include "assert_macros.svh"

module lcsr_checker
    import lcsr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `ASSERT_CLK(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `ASSERT_CLK(a_timeout_raw, aclk, aresetn, m_tvalid && m_tdata[3] |-> m_tdata[2] && (m_tdata[27:4] == '0), "timeout without done or with nonzero raw")
    `ASSERT_CLK(a_sck_busy, aclk, aresetn, m_tvalid && m_tdata[0] |-> m_tdata[1], "serial clock driven while idle")
    `ASSERT_CLK(a_done_busy, aclk, aresetn, m_tvalid && m_tdata[2] |-> m_tdata[1], "completion reported outside a readout")

endmodule

bind load_cell_adc_serial_reader lcsr_checker u_lcsr_checker (.*);

// ----- sim/tb_load_cell_adc_serial_reader.sv -----
// Self-checking testbench for the load cell serial reader: drives tick streams, predicts every
// result tick with an in-bench sequencer and weight model, and compares field by field.
// Depends on lcsr_pkg and load_cell_adc_serial_reader.
module tb_load_cell_adc_serial_reader;
    import lcsr_pkg::*;

    typedef struct packed {
        logic                sck;
        logic                busy;
        logic                done;
        logic                tmo;
        logic [RAW_W-1:0]    raw;
        logic [WEIGHT_W-1:0] wgt;
    } reading_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    load_cell_adc_serial_reader i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [S_TDATA_W-1:0] tick_q[$];
    reading_t             reading_q[$];

    logic [RAW_W-1:0]    cur_offset = OFFSET_RST;
    logic [SCALE_W-1:0]  cur_scale = SCALE_RST;
    logic [PHASE_W-1:0]  cur_phase = PHASE_RST;
    logic [WAIT_W-1:0]   cur_timeout = TIMEOUT_RST;

    lcsr_state_t         seq_state = ST_IDLE;
    logic [BITCNT_W-1:0] bit_cnt = '0;
    logic [PHASE_W-1:0]  ph_cnt = '0;
    logic [WAIT_W-1:0]   wait_cnt = '0;
    logic [RAW_W-1:0]    shift_reg = '0;
    logic [RAW_W-1:0]    held_raw = '0;
    logic [WEIGHT_W-1:0] held_wgt = '0;

    bit       gaps_on = 1'b1;
    int       send_gap = 0;
    int       rdy_gap = 0;
    int       hold_left = 0;
    int       n_errors = 0;
    int       n_checked = 0;
    int       n_pushed = 0;
    int       n_readouts = 0;
    int       n_timeouts = 0;
    int       n_settings = 1;
    reading_t want;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [RAW_W-1:0] raw);
        longint d;
        longint p;
        d = longint'($signed(raw)) - longint'($signed(cur_offset));
        p = d * longint'({32'b0, cur_scale});
        return WEIGHT_W'(p >>> FRAC_SHIFT);
    endfunction

    function automatic bit phase_over();
        int len;
        len = (cur_phase == 0) ? 1 : int'(cur_phase);
        if (ph_cnt + 1 >= len) begin
            ph_cnt = '0;
            return 1'b1;
        end
        ph_cnt = ph_cnt + 1'b1;
        return 1'b0;
    endfunction

    function automatic void finish_reading(input logic [RAW_W-1:0] raw);
        held_raw = raw;
        held_wgt = weight_of(raw);
        seq_state = ST_IDLE;
        bit_cnt = '0;
        ph_cnt = '0;
        wait_cnt = '0;
    endfunction

    function automatic void predict_tick(input logic start, input logic dt);
        reading_t r;
        r = '0;
        case (seq_state)
            ST_IDLE: begin
                if (start) begin
                    seq_state = ST_WAIT;
                    wait_cnt = '0;
                end
            end
            ST_WAIT: begin
                r.busy = 1'b1;
                if (!dt) begin
                    seq_state = ST_HIGH;
                    bit_cnt = '0;
                    ph_cnt = '0;
                    shift_reg = '0;
                end else begin
                    wait_cnt = wait_cnt + 1'b1;
                    if (wait_cnt >= cur_timeout) begin
                        finish_reading('0);
                        r.done = 1'b1;
                        r.tmo = 1'b1;
                        n_timeouts++;
                    end
                end
            end
            ST_HIGH: begin
                r.busy = 1'b1;
                r.sck = 1'b1;
                if (phase_over()) seq_state = ST_LOW;
            end
            ST_LOW: begin
                r.busy = 1'b1;
                if (phase_over()) begin
                    shift_reg = {shift_reg[RAW_W-2:0], dt};
                    bit_cnt = bit_cnt + 1'b1;
                    seq_state = (bit_cnt >= DATA_BITS) ? ST_GAIN : ST_HIGH;
                end
            end
            ST_GAIN: begin
                r.busy = 1'b1;
                r.sck = 1'b1;
                if (phase_over()) begin
                    finish_reading(shift_reg);
                    r.done = 1'b1;
                    n_readouts++;
                end
            end
            default: seq_state = ST_IDLE;
        endcase
        r.raw = held_raw;
        r.wgt = held_wgt;
        reading_q.push_back(r);
    endfunction

    task automatic report_err(input string what, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
        n_errors++;
        if (n_errors <= 50)
            $display("ERROR: result %0d %s: expected %0h, got %0h", n_checked, what, exp_v, got_v);
    endtask

    // Sender: one tick request per handshake, with random gaps while gaps_on is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_tick(s_tdata[0], s_tdata[1]);
                void'(tick_q.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap == 0 && gaps_on && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 7);
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (tick_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= tick_q[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reading_q.size() == 0) begin
                    report_err("result with no request pending", '0, m_tdata[63:0]);
                end else begin
                    want = reading_q.pop_front();
                    if (m_tdata[0] !== want.sck)
                        report_err("sck", 64'(want.sck), 64'(m_tdata[0]));
                    if (m_tdata[1] !== want.busy)
                        report_err("busy_res", 64'(want.busy), 64'(m_tdata[1]));
                    if (m_tdata[2] !== want.done)
                        report_err("done_res", 64'(want.done), 64'(m_tdata[2]));
                    if (m_tdata[3] !== want.tmo)
                        report_err("timed_out", 64'(want.tmo), 64'(m_tdata[3]));
                    if (m_tdata[4 +: RAW_W] !== want.raw)
                        report_err("raw_value", 64'(want.raw), 64'(m_tdata[4 +: RAW_W]));
                    if (m_tdata[4 + RAW_W +: WEIGHT_W] !== want.wgt)
                        report_err("weight_q16", 64'(want.wgt),
                                   64'(m_tdata[4 + RAW_W +: WEIGHT_W]));
                    n_checked++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (rdy_gap == 0 && gaps_on && $urandom_range(0, 7) == 0)
                    rdy_gap = $urandom_range(1, 7);
                if (rdy_gap > 0) begin
                    rdy_gap--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic wr_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ZERO_OFFSET:   cur_offset = val[RAW_W-1:0];
            REG_SCALE:         cur_scale = val;
            REG_PHASE_TICKS:   cur_phase = val[PHASE_W-1:0];
            REG_READY_TIMEOUT: cur_timeout = val[WAIT_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    function automatic void push_tick(input bit start, input bit dt);
        tick_q.push_back(S_TDATA_W'({dt, start}));
        n_pushed++;
    endfunction

    function automatic void push_noise(input int n);
        repeat (n) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // One well-formed readout: start, n_high busy samples, ready, then a clock pulse per data bit and the gain pulse.
    function automatic void push_conv(input logic [RAW_W-1:0] bits, input int n_high);
        int ph;
        ph = (cur_phase == 0) ? 1 : int'(cur_phase);
        push_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (n_high) push_tick(1'($urandom_range(0, 1)), 1'b1);
        push_tick(1'($urandom_range(0, 1)), 1'b0);
        for (int b = DATA_BITS - 1; b >= 0; b--) begin
            push_noise(2 * ph - 1);
            push_tick(1'($urandom_range(0, 1)), bits[b]);
        end
        push_noise(ph);
    endfunction

    function automatic void push_timeout();
        push_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat ((cur_timeout == 0) ? 1 : int'(cur_timeout))
            push_tick(1'($urandom_range(0, 1)), 1'b1);
    endfunction

    task automatic drain();
        @(negedge aclk);
        while (tick_q.size() != 0 || reading_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Drains, then clocks a partial readout to completion so registers can change.
    task automatic settle();
        drain();
        if (seq_state != ST_IDLE) begin
            repeat (51 * ((cur_phase == 0) ? 1 : int'(cur_phase)) + 4) push_tick(1'b0, 1'b0);
            drain();
        end
    endtask

    initial begin
        int rnd_base;
        int rounds;
        int r;
        int hi;
        reading_t left;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        push_conv(24'h7FFFFF, 0);
        push_conv(24'h800000, 3);
        push_noise(4);
        settle();

        wr_reg(REG_ZERO_OFFSET, 32'h0080_0000);
        wr_reg(REG_SCALE, 32'hFFFF_FFFF);
        wr_reg(REG_PHASE_TICKS, 32'd0);
        wr_reg(REG_READY_TIMEOUT, 32'd0);
        n_settings++;
        push_conv(24'h7FFFFF, 0);
        push_timeout();
        push_noise(3);
        settle();

        wr_reg(REG_ZERO_OFFSET, 32'h007F_FFFF);
        wr_reg(REG_PHASE_TICKS, 32'd1);
        wr_reg(REG_READY_TIMEOUT, 32'd2);
        n_settings++;
        push_conv(24'h800000, 1);
        push_timeout();
        push_conv(24'h000000, 0);
        push_conv(24'hFFFFFF, 1);
        settle();

        wr_reg(REG_SCALE, 32'd0);
        wr_reg(REG_READY_TIMEOUT, 32'h00FF_FFFF);
        n_settings++;
        push_conv(24'($urandom), 2);
        settle();

        wr_reg(REG_PHASE_TICKS, 32'd255);
        wr_reg(REG_READY_TIMEOUT, 32'd1);
        n_settings++;
        push_timeout();
        settle();

        rnd_base = n_pushed;
        rounds = 0;
        hi = 0;
        while (n_pushed - rnd_base < 300) begin
            case ($urandom_range(0, 5))
                0: wr_reg(REG_ZERO_OFFSET, 32'h0080_0000);
                1: wr_reg(REG_ZERO_OFFSET, 32'h007F_FFFF);
                default: wr_reg(REG_ZERO_OFFSET, {8'h00, 24'($urandom)});
            endcase
            case ($urandom_range(0, 7))
                0: wr_reg(REG_SCALE, 32'd0);
                1: wr_reg(REG_SCALE, 32'hFFFF_FFFF);
                default: wr_reg(REG_SCALE, $urandom);
            endcase
            wr_reg(REG_PHASE_TICKS, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 3));
            case ($urandom_range(0, 3))
                0, 1: wr_reg(REG_READY_TIMEOUT, $urandom_range(0, 6));
                2: wr_reg(REG_READY_TIMEOUT, 32'd150000);
                default: wr_reg(REG_READY_TIMEOUT, 32'h00FF_FFFF);
            endcase
            n_settings++;
            hi = (cur_timeout == 0) ? 0 : ((cur_timeout > 8) ? 8 : int'(cur_timeout) - 1);
            for (int k = n_pushed; n_pushed - k < 120;) begin
                r = $urandom_range(0, 19);
                if (r < 14)
                    push_conv(24'($urandom), $urandom_range(0, hi));
                else if (r < 17 && cur_timeout <= 8)
                    push_timeout();
                else
                    push_noise($urandom_range(5, 30));
            end
            if (rounds == 0) begin
                @(negedge aclk);
                hold_left = 400;
            end
            settle();
            rounds++;
        end

        gaps_on = 1'b0;
        repeat (8) @(negedge aclk);
        push_conv(24'($urandom), 0);
        push_conv(24'($urandom), hi);
        push_noise(20);
        settle();

        repeat (20) @(posedge aclk);
        while (reading_q.size() > 0) begin
            left = reading_q.pop_front();
            report_err("prediction left without result", 64'(left.raw), '0);
        end
        $display("Checked %0d result ticks: %0d readouts and %0d timeouts predicted.",
                 n_checked, n_readouts, n_timeouts);
        $display("Used %0d register settings, including the extremes of every register.",
                 n_settings);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lcsr_pkg.sv
hdl/lcsr_ctrl.sv
hdl/load_cell_adc_serial_reader.sv
hdl/lcsr_checker.sv
sim/tb_load_cell_adc_serial_reader.sv
